/* sv/sorted_set_min_max_extract_macros.svh */
// assertion helpers, sampled on clk and disabled while arst_n is low
`ifndef SORTED_SET_MIN_MAX_EXTRACT_MACROS_SVH
`define SORTED_SET_MIN_MAX_EXTRACT_MACROS_SVH

// same-cycle implication
`define SSMMX_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ssmmx assertion failed");

// next-cycle implication
`define SSMMX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ssmmx assertion failed");

`endif

/* sv/ssmmx_pkg.sv */
`default_nettype none
package ssmmx_pkg;

	localparam int DEPTH = 64;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam logic [VAL_W-1:0] SIGN_BIAS = 32'h8000_0000;

	typedef enum logic [1:0] {
		CMD_INSERT      = 2'd0,
		CMD_EXTRACT_MAX = 2'd1,
		CMD_EXTRACT_MIN = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_DUP   = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;  // capture the incoming word
		logic exec;  // apply the operation and load the result register
	} dp_cmd_t;

endpackage
`default_nettype wire

/* sv/ssmmx_ctrl.sv */
`default_nettype none
module ssmmx_ctrl import ssmmx_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && !m_tready;
		s_tready    = 1'b0;
		cmd         = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// wait until the output register is free
				if (!out_valid_q || m_tready) begin
					cmd.exec    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule
`default_nettype wire

/* sv/ssmmx_dp.sv */
`default_nettype none
module ssmmx_dp import ssmmx_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	input  logic [1:0]       op,
	input  logic [VAL_W-1:0] value,
	output logic [VAL_W-1:0] result_value,
	output logic [1:0]       status
);

	logic [1:0]       op_q;
	logic [VAL_W-1:0] key_q;     // sign-flipped so unsigned compare gives signed order
	logic [VAL_W-1:0] cell_q [DEPTH];
	logic [CNT_W-1:0] count_q;
	logic [VAL_W-1:0] res_q;
	logic [1:0]       stat_q;

	logic [DEPTH-1:0] valid, lt, eq, last;
	logic [VAL_W-1:0] ins_next [DEPTH];
	logic [VAL_W-1:0] shr_next [DEPTH];
	logic [VAL_W-1:0] max_val;
	logic             dup, full, empty;

	logic             do_ins, do_shr;
	logic [CNT_W-1:0] count_d;
	logic [VAL_W-1:0] res_d;
	logic [1:0]       stat_d;

	genvar g;
	for (g = 0; g < DEPTH; g++) begin : g_cell
		assign valid[g] = CNT_W'(g) < count_q;
		assign lt[g]    = valid[g] && (cell_q[g] < key_q);
		assign eq[g]    = valid[g] && (cell_q[g] == key_q);
		assign last[g]  = valid[g] && (CNT_W'(g + 1) == count_q);
		if (g == 0) begin : g_first
			assign ins_next[g] = lt[g] ? cell_q[g] : key_q;
		end else begin : g_rest
			assign ins_next[g] = lt[g] ? cell_q[g] : (lt[g-1] ? key_q : cell_q[g-1]);
		end
		if (g == DEPTH - 1) begin : g_top
			assign shr_next[g] = cell_q[g];
		end else begin : g_low
			assign shr_next[g] = cell_q[g+1];
		end
	end

	// the top valid cell holds the maximum
	always_comb begin
		max_val = '0;
		for (int i = 0; i < DEPTH; i++) begin
			max_val = max_val | (last[i] ? cell_q[i] : '0);
		end
	end

	assign dup   = |eq;
	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;

	always_comb begin
		do_ins  = 1'b0;
		do_shr  = 1'b0;
		count_d = count_q;
		res_d   = '0;
		stat_d  = STAT_OK;
		case (op_q)
			CMD_INSERT: begin
				if (dup) begin
					stat_d = STAT_DUP;
				end else if (full) begin
					stat_d = STAT_FULL;
				end else begin
					do_ins  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_EXTRACT_MAX: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					res_d   = max_val ^ SIGN_BIAS;
					count_d = count_q - CNT_W'(1);
				end
			end
			CMD_EXTRACT_MIN: begin
				if (empty) begin
					stat_d = STAT_EMPTY;
				end else begin
					res_d   = cell_q[0] ^ SIGN_BIAS;
					do_shr  = 1'b1;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				stat_d = STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.exec) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			key_q <= value ^ SIGN_BIAS;
		end
		if (cmd.exec) begin
			res_q  <= res_d;
			stat_q <= stat_d;
			for (int i = 0; i < DEPTH; i++) begin
				if (do_ins) begin
					cell_q[i] <= ins_next[i];
				end else if (do_shr) begin
					cell_q[i] <= shr_next[i];
				end
			end
		end
	end

	assign result_value = res_q;
	assign status       = stat_q;

endmodule
`default_nettype wire

/* sv/sorted_set_min_max_extract.sv */
// sorted set of distinct signed 32-bit values with min and max extraction
//
// input channel s_*: one word per command. s_tuser[1:0] is the command
// (insert, extract max, extract min), s_tdata[31:0] the value to insert.
// output channel m_*: one word per command. m_tdata[31:0] is the extracted
// value (zero unless an extraction succeeded), m_tuser[1:0] the status
// (ok, empty, duplicate ignored, full).
//
// every command is first captured, then the row of compare-and-shift cells
// resolves the operation in the execute step and loads the output register.
// the result becomes valid when the output register is loaded, and no new
// word is taken until the execute step of the last one is done.
// the output register frees the input side: the next word is taken while
// a result still waits. if the receiver holds m_tready low, the block
// stalls in the execute step and s_tready stays low until the result moves.
//
// reset empties the set at once (count cleared); no clearing pass is needed
`default_nettype none
`include "sorted_set_min_max_extract_macros.svh"
module sorted_set_min_max_extract import ssmmx_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] result_value
	output logic [1:0]  m_tuser    // [1:0] status
);

	dp_cmd_t cmd;

	// sequencing: capture, then execute when the output register is free
	ssmmx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// cell row, entry count and output register
	ssmmx_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.op           (s_tuser),
		.value        (s_tdata),
		.result_value (m_tdata),
		.status       (m_tuser)
	);

	// one command in flight: no word taken right after a word is taken
	`SSMMX_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// only a successful extraction carries a nonzero value
	`SSMMX_ASSERT_SAME(a_zero_on_fault, m_tvalid && (m_tuser != STAT_OK), m_tdata == '0)
	// a new result is only produced in the execute step
	`SSMMX_ASSERT_SAME(a_result_from_exec, $rose(m_tvalid), !$past(s_tready))

endmodule
`default_nettype wire
